// ----- hdl/point_in_polygon_test_assert.svh -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_assert.svh
// Assertion macros shared by the point-in-polygon checker.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared codes, widths and control/status types of the point-in-polygon block.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  localparam int IDX_W = 6;   // vertex_index field width
  localparam int CFG_W = 7;   // vertex_count register width

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic vtx_wr;     // write one vertex into the store
    logic point_ld;   // capture query point, clear inside flag
    logic rd_prime;   // read in flight is the last vertex (edge seed)
    logic rd_edge;    // read in flight is an edge's current vertex
  } pip_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;         // edge pipeline still holds work
    logic crossed_odd;  // running even-odd flag
  } pip_sts_t;

endpackage

`default_nettype wire

// ----- hdl/pip_in_if.sv -----
// ----------------------------------------------------------------------------
// pip_in_if
// Input channel: vertex load and point query transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_in_if
  import pip_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) ();

  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [IDX_W-1:0]              vertex_index;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (
    output valid, op, vertex_index, vertex_x, vertex_y, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, op, vertex_index, vertex_x, vertex_y, point_x, point_y,
    output ready
  );

endinterface

`default_nettype wire

// ----- hdl/pip_out_if.sv -----
// ----------------------------------------------------------------------------
// pip_out_if
// Result channel: one inside/outside flag per query transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_out_if ();

  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );

  modport sink (
    input  valid, inside_res,
    output ready
  );

endinterface

`default_nettype wire

// ----- hdl/pip_ctrl.sv -----
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer: vertex_count register, edge walk, pipeline drain, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_ctrl
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_op,
  output logic                                   in_ready,
  input  wire logic                              cfg_we,
  input  wire logic [CFG_W-1:0]                  cfg_wdata,
  output pip_cmd_t                               cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
  input  wire pip_sts_t                          sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_inside
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int KW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   vcount_r;
  logic [AW-1:0]      idx_r;
  logic [AW-1:0]      last_r;
  logic [AW-1:0]      rd_addr_r;
  logic               prime_r;
  logic               edge_r;
  logic               out_valid_r;
  logic               out_inside_r;

  logic [KW-1:0]      cfg_ext;
  logic [KW-1:0]      max_ext;
  logic [CW-1:0]      n_now;
  logic               acc;
  logic               fin_go;

  assign cfg_ext = KW'(vcount_r);
  assign max_ext = KW'(MAX_VERTICES);
  assign n_now   = (cfg_ext > max_ext) ? CW'(max_ext) : CW'(cfg_ext);

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  // result register free (or draining this cycle) in the finish state
  assign fin_go = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  assign cmd = '{vtx_wr:   acc && (in_op == OP_LOAD),
                 point_ld: acc && (in_op == OP_QUERY),
                 rd_prime: prime_r,
                 rd_edge:  edge_r};
  assign rd_addr = rd_addr_r;

  assign out_valid  = out_valid_r;
  assign out_inside = out_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      prime_r     <= 1'b0;
      edge_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          edge_r <= 1'b0;
          if (acc && (in_op == OP_QUERY)) begin
            if (n_now == '0) begin
              prime_r <= 1'b0;
              state_r <= S_FINISH;
            end else begin
              rd_addr_r <= AW'(n_now - CW'(1));
              last_r    <= AW'(n_now - CW'(1));
              idx_r     <= '0;
              prime_r   <= 1'b1;
              state_r   <= S_WALK;
            end
          end else begin
            prime_r <= 1'b0;
          end
        end
        S_WALK: begin
          prime_r   <= 1'b0;
          rd_addr_r <= idx_r;
          edge_r    <= 1'b1;
          if (idx_r == last_r) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        S_DRAIN: begin
          prime_r <= 1'b0;
          edge_r  <= 1'b0;
          if (!edge_r && !sts.busy) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          prime_r <= 1'b0;
          edge_r  <= 1'b0;
          if (fin_go) begin
            out_inside_r <= sts.crossed_odd;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          prime_r <= 1'b0;
          edge_r  <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pip_dp.sv -----
// ----------------------------------------------------------------------------
// pip_dp
// Vertex store and three-stage edge pipeline: read, cross products, compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_dp
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pip_cmd_t                          cmd,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
  input  wire logic [IDX_W-1:0]                  vertex_index,
  input  wire logic signed [COORD_WIDTH-1:0]     vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0]     vertex_y,
  input  wire logic signed [COORD_WIDTH-1:0]     point_x,
  input  wire logic signed [COORD_WIDTH-1:0]     point_y,
  output pip_sts_t                               sts
);

  localparam int W  = COORD_WIDTH;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int EW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int PW = 2 * W + 2;

  // entries packed as {y, x}
  logic [2*W-1:0]        mem [MAX_VERTICES];
  logic [2*W-1:0]        rd_data_r;
  logic [2*W-1:0]        prev_r;
  logic signed [W-1:0]   px_r;
  logic signed [W-1:0]   py_r;
  logic                  prime_q;
  logic                  edge_q;
  logic                  v2_r;
  logic                  hit_r;
  logic                  neg_r;
  logic signed [PW-1:0]  lhs_r;
  logic signed [PW-1:0]  rhs_r;
  logic                  inside_r;

  logic [EW-1:0]         idx_ext;
  logic                  wr_ok;
  logic signed [W-1:0]   x1, y1, x2, y2;
  logic signed [W:0]     dxp, dy, dx, dq;
  logic                  straddle;
  logic                  left;

  assign idx_ext = EW'(vertex_index);
  assign wr_ok   = idx_ext < EW'(MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (cmd.vtx_wr && wr_ok) begin
      mem[idx_ext[AW-1:0]] <= {vertex_y, vertex_x};
    end
    rd_data_r <= mem[rd_addr];
  end

  // edge i runs from current vertex (x1,y1) back to previous (x2,y2)
  assign x1 = rd_data_r[W-1:0];
  assign y1 = rd_data_r[2*W-1:W];
  assign x2 = prev_r[W-1:0];
  assign y2 = prev_r[2*W-1:W];

  assign dxp = $signed({px_r[W-1], px_r}) - $signed({x1[W-1], x1});
  assign dy  = $signed({y2[W-1], y2})     - $signed({y1[W-1], y1});
  assign dx  = $signed({x2[W-1], x2})     - $signed({x1[W-1], x1});
  assign dq  = $signed({py_r[W-1], py_r}) - $signed({y1[W-1], y1});

  assign straddle = (y1 > py_r) != (y2 > py_r);

  // dy is never zero on a straddling edge; its sign flips the sense
  assign left = neg_r ? (lhs_r > rhs_r) : (lhs_r < rhs_r);

  always_ff @(posedge clk) begin
    if (cmd.point_ld) begin
      px_r <= point_x;
      py_r <= point_y;
    end
    if (prime_q || edge_q) begin
      prev_r <= rd_data_r;
    end
    lhs_r <= PW'(dxp) * PW'(dy);
    rhs_r <= PW'(dx) * PW'(dq);
    neg_r <= dy[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_q  <= 1'b0;
      edge_q   <= 1'b0;
      v2_r     <= 1'b0;
      hit_r    <= 1'b0;
      inside_r <= 1'b0;
    end else begin
      prime_q <= cmd.rd_prime;
      edge_q  <= cmd.rd_edge;
      v2_r    <= edge_q;
      hit_r   <= edge_q && straddle;
      if (cmd.point_ld) begin
        inside_r <= 1'b0;
      end else if (hit_r && left) begin
        inside_r <= ~inside_r;
      end
    end
  end

  assign sts = '{busy:        prime_q || edge_q || v2_r,
                 crossed_odd: inside_r};

endmodule

`default_nettype wire

// ----- hdl/point_in_polygon_test.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a point against a stored polygon.
// ----------------------------------------------------------------------------
//  channel   dir  transaction                     result
//  in_chan   in   load vertex / query point       load: none, query: one
//  out_chan  out  inside_res flag                 -
//  cfg_*     in   vertex_count write              -
//
//  Load: taken back to back while no query runs.
//  Query: the walk covers vertex_count edges (count saturated at
//  MAX_VERTICES, no walk for a count of zero), paced by the single read port
//  of the vertex store, one edge fetched per cycle; input closed meanwhile.
//  Reset clears the controller and pipeline; the store is not cleared.
//  A finished result sits in the output register while new loads or a new
//  query are taken; a query holds in its last state until out_chan drains.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pip_in_if.sink                 in_chan,
  pip_out_if.source              out_chan,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_VERTICES);

  pip_cmd_t       cmd;
  pip_sts_t       sts;
  logic [AW-1:0]  rd_addr;

  // sequencer: walk order is last vertex (seed), then 0 .. n-1
  pip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_op      (in_chan.op),
    .in_ready   (in_chan.ready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .sts        (sts),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_inside (out_chan.inside_res)
  );

  // store + exact cross-multiplied crossing compare
  pip_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .vertex_index (in_chan.vertex_index),
    .vertex_x     (in_chan.vertex_x),
    .vertex_y     (in_chan.vertex_y),
    .point_x      (in_chan.point_x),
    .point_y      (in_chan.point_y),
    .sts          (sts)
  );

endmodule

`default_nettype wire

// ----- hdl/pip_checker.sv -----
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks of the point-in-polygon block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_in_polygon_test_assert.svh"

module pip_checker
  import pip_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_op,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic inside_res
);

  // stalled result holds
  `PIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(inside_res), "result dropped or changed while stalled")

  // loads never block the input
  `PIP_ASSERT_NEXT(a_load_1cyc, clk, rst_n, in_valid && in_ready && (in_op == OP_LOAD), in_ready, "input blocked after a load")

  // a query occupies the block
  `PIP_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && in_ready && (in_op == OP_QUERY), !in_ready, "input open while a query runs")

  // results come only out of a running query
  `PIP_ASSERT_IMPL(a_res_src, clk, rst_n, $rose(out_valid), $past(!in_ready), "result without a running query")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_op      (in_chan.op),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .inside_res (out_chan.inside_res)
);

`default_nettype wire

// ----- tb/point_in_polygon_test_tb.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb
// Self-checking bench for the even-odd point-in-polygon block. Vertex loads
// and point queries are driven over the input channel, and a local copy of
// the vertex store and count predicts each inside flag. Results are compared
// in order on the output channel. Both channels see random idle and stall
// patterns, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb import pip_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VERTS   = 64;
  localparam int COORD_W     = 16;
  localparam int CLK_PERIOD  = 8;
  // A query walks every edge plus a few pipeline stages; allow margin.
  localparam int SETTLE_CYC  = MAX_VERTS + 16;
  localparam int ITEM_TARGET = 1550;

  // One input transaction as the sender sees it.
  typedef struct {
    logic                      op;
    logic [IDX_W-1:0]          index;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } pip_txn_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  pip_in_if #(.COORD_WIDTH(COORD_W)) in_if ();
  pip_out_if                          out_if ();

  point_in_polygon_test #(
    .MAX_VERTICES(MAX_VERTS),
    .COORD_WIDTH (COORD_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the block: vertex store and count register.
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] vx_store [MAX_VERTS];
  logic signed [COORD_W-1:0] vy_store [MAX_VERTS];
  logic [CFG_W-1:0]          vertex_count_cfg;

  // Inside flags still owed by the block, oldest first.
  logic expected_inside_q[$];

  int   err_count    = 0;
  int   items_sent   = 0;
  bit   src_idle_en  = 1'b0;
  bit   snk_stall_en = 1'b0;
  int   hold_request = 0;   // long output hold-off, picked up by the receiver
  logic want_inside;

  // Even-odd crossing count over the shadow polygon. The crossing compare is
  // done cross-multiplied in 64 bits, so it is exact; the sense flips when
  // the edge runs downward.
  function automatic logic predict_inside(int px, int py);
    int     n, i, j;
    longint x1, y1, x2, y2, dy, lhs, rhs;
    logic   flag;
    n    = (vertex_count_cfg > MAX_VERTS) ? MAX_VERTS : int'(vertex_count_cfg);
    flag = 1'b0;
    for (i = 0; i < n; i++) begin
      j  = (i == 0) ? n - 1 : i - 1;
      x1 = vx_store[i];
      y1 = vy_store[i];
      x2 = vx_store[j];
      y2 = vy_store[j];
      // horizontal edges never straddle, so they never toggle
      if ((y1 > py) != (y2 > py)) begin
        dy  = y2 - y1;
        lhs = (px - x1) * dy;
        rhs = (x2 - x1) * (py - y1);
        // strictly left only: a point on the crossing does not toggle
        if (dy > 0 ? (lhs < rhs) : (lhs > rhs))
          flag = ~flag;
      end
    end
    return flag;
  endfunction

  // Most gaps are zero or short, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // --------------------------------------------------------------------------
  // Sender. A transaction is driven at the falling edge and held until it is
  // taken at a rising edge; the shadow model is updated at that same edge.
  // valid stays high between back-to-back transactions.
  // --------------------------------------------------------------------------
  task automatic send_txn(input pip_txn_t t);
    int gap;
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.op           <= t.op;
    in_if.vertex_index <= t.index;
    in_if.vertex_x     <= t.vx;
    in_if.vertex_y     <= t.vy;
    in_if.point_x      <= t.px;
    in_if.point_y      <= t.py;
    @(posedge clk);
    while (!in_if.ready)
      @(posedge clk);
    items_sent++;
    if (t.op == OP_LOAD) begin
      vx_store[t.index] = t.vx;
      vy_store[t.index] = t.vy;
    end else begin
      expected_inside_q = {expected_inside_q,
                           predict_inside(int'(t.px), int'(t.py))};
    end
    if (src_idle_en) begin
      gap = gap_cycles();
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_load(int slot, int x, int y);
    pip_txn_t t;
    t.op    = OP_LOAD;
    t.index = IDX_W'(slot);
    t.vx    = COORD_W'(x);
    t.vy    = COORD_W'(y);
    t.px    = COORD_W'(rand_coord());
    t.py    = COORD_W'(rand_coord());
    send_txn(t);
  endtask

  task automatic send_query(int x, int y);
    pip_txn_t t;
    t.op    = OP_QUERY;
    t.index = IDX_W'($urandom_range(0, MAX_VERTS - 1));
    t.vx    = COORD_W'(rand_coord());
    t.vy    = COORD_W'(rand_coord());
    t.px    = COORD_W'(x);
    t.py    = COORD_W'(y);
    send_txn(t);
  endtask

  // Stop offering, wait until every query has answered, then give the
  // block time to settle before the next step.
  task automatic drain_and_settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_inside_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_vertex_count(int n);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(n);
    @(negedge clk);
    cfg_we    <= 1'b0;
    vertex_count_cfg = CFG_W'(n);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or one long hold-off when a test asks for it.
  // ready changes only at the falling edge.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && snk_stall_en && $urandom_range(0, 3) == 0) begin
        stall_left = gap_cycles();
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Checker: every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_inside_q.size() == 0) begin
        err_count++;
        $display("%0t: result with no query pending: expected none, actual inside_res=%0b",
                 $time, out_if.inside_res);
      end else begin
        want_inside = expected_inside_q.pop_front();
        if (out_if.inside_res !== want_inside) begin
          err_count++;
          $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                   $time, want_inside, out_if.inside_res);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty polygon: any point is outside, extremes included.
  task automatic test_empty_polygon();
    write_vertex_count(0);
    send_query(-32768, -32768);
    send_query(32767, 32767);
  endtask

  // Square on the coordinate extremes: points on its horizontal edges, on
  // its vertical edges, in the middle and just inside the bottom edge.
  task automatic test_extreme_square();
    send_load(0, -32768, -32768);
    send_load(1, 32767, -32768);
    send_load(2, 32767, 32767);
    send_load(3, -32768, 32767);
    drain_and_settle();
    write_vertex_count(4);
    send_query(0, 0);
    send_query(-32768, 0);
    send_query(32767, 0);
    send_query(0, -32768);
    send_query(0, 32767);
    send_query(-1, -32767);
  endtask

  // Small triangle: points exactly on the slanted edges, on the apex, on
  // the flat base and one inside; then degenerate one- and two-vertex polygons.
  task automatic test_triangle_edges();
    send_load(0, 0, 0);
    send_load(1, 64, 0);
    send_load(2, 32, 64);
    send_load(63, 32767, -32768);   // top slot, never read at these counts
    drain_and_settle();
    write_vertex_count(3);
    send_query(16, 32);
    send_query(48, 32);
    send_query(32, 64);
    send_query(10, 0);
    send_query(32, 10);
    drain_and_settle();
    write_vertex_count(1);
    send_query(0, 0);
    drain_and_settle();
    write_vertex_count(2);
    send_query(32, 0);
  endtask

  // Receiver holds off for a long stretch while queries keep coming, so the
  // finished result parks in the output register and the input backs up.
  task automatic test_output_hold_off();
    int i;
    drain_and_settle();
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    for (i = 0; i < 6; i++)
      send_load(i, rand_between(-4000, 4000), rand_between(-4000, 4000));
    drain_and_settle();
    write_vertex_count(6);
    hold_request = 500;
    for (i = 0; i < 16; i++)
      send_query(rand_between(-4000, 4000), rand_between(-4000, 4000));
    drain_and_settle();
  endtask

  function automatic int pick_vertex_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(3, 8);
    if (r < 60) return $urandom_range(9, 24);
    if (r < 70) return $urandom_range(25, 63);
    if (r < 78) return MAX_VERTS;
    if (r < 84) return $urandom_range(MAX_VERTS + 1, (1 << CFG_W) - 1);
    if (r < 92) return 0;
    return $urandom_range(1, 2);
  endfunction

  // Query points lean toward the polygon's own features (vertices, vertex
  // rows and columns, edge midpoints) where the exact compare matters.
  function automatic void pick_point(input int m, input int lo, input int hi,
                                     output int px, output int py);
    int a, b, kind;
    kind = (m == 0) ? $urandom_range(0, 1) : $urandom_range(0, 6);
    a    = (m == 0) ? 0 : $urandom_range(0, m - 1);
    b    = (a == 0) ? m - 1 : a - 1;
    case (kind)
      0: begin
        px = rand_coord();
        py = rand_coord();
      end
      3: begin
        px = vx_store[a];
        py = vy_store[a];
      end
      4: begin
        px = rand_between(lo, hi);
        py = vy_store[a];
      end
      5: begin
        px = (int'(vx_store[a]) + int'(vx_store[b])) >>> 1;
        py = (int'(vy_store[a]) + int'(vy_store[b])) >>> 1;
      end
      6: begin
        px = vx_store[a];
        py = rand_between(lo, hi);
      end
      default: begin
        px = rand_between(lo, hi);
        py = rand_between(lo, hi);
      end
    endcase
  endfunction

  // Phases of: drain, set a count, load a fresh polygon in random slot
  // order, then a run of queries with stray loads mixed in. The first
  // phases pin the count extremes, including the saturating one.
  task automatic test_random_polygons();
    int fixed_counts[5] = '{MAX_VERTS, (1 << CFG_W) - 1, 0, 1, 2};
    int slot_order[MAX_VERTS];
    int phase, n, m, span, lo, hi, k, i, swap_at, tmp, px, py, r;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      n = (phase < 5) ? fixed_counts[phase] : pick_vertex_count();
      phase++;
      m = (n > MAX_VERTS) ? MAX_VERTS : n;
      case ($urandom_range(0, 3))
        0:       span = 16;
        1:       span = 256;
        2:       span = 4096;
        default: span = 65535;
      endcase
      lo = -32768 + int'($urandom_range(0, 65535 - span));
      hi = lo + span;

      drain_and_settle();
      src_idle_en  = ($urandom_range(0, 3) != 0);
      snk_stall_en = ($urandom_range(0, 3) != 0);
      write_vertex_count(n);

      for (i = 0; i < m; i++)
        slot_order[i] = i;
      for (i = m - 1; i > 0; i--) begin
        swap_at             = $urandom_range(0, i);
        tmp                 = slot_order[i];
        slot_order[i]       = slot_order[swap_at];
        slot_order[swap_at] = tmp;
      end
      for (i = 0; i < m; i++)
        send_load(slot_order[i], rand_between(lo, hi), rand_between(lo, hi));

      k = $urandom_range(8, 30);
      for (i = 0; i < k; i++) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          send_load($urandom_range(0, MAX_VERTS - 1), rand_between(lo, hi),
                    rand_between(lo, hi));
        end else if (r < 16) begin
          send_load($urandom_range(0, MAX_VERTS - 1), rand_coord(), rand_coord());
        end else begin
          pick_point(m, lo, hi, px, py);
          send_query(px, py);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.op           = OP_LOAD;
    in_if.vertex_index = '0;
    in_if.vertex_x     = '0;
    in_if.vertex_y     = '0;
    in_if.point_x      = '0;
    in_if.point_y      = '0;
    vertex_count_cfg   = '0;
    for (int s = 0; s < MAX_VERTS; s++) begin
      vx_store[s] = '0;
      vy_store[s] = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_polygon();
    test_extreme_square();
    test_triangle_edges();
    test_output_hold_off();
    test_random_polygons();

    drain_and_settle();
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
